// ===== design/hnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnm_pkg: shared types and constants of the heartbeat node monitor
// Actions, result kinds, register indexes and the front-to-back command word.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int MaxNodesDefault = 16;
  localparam int QueueDepth      = 4;

  localparam logic [10:0] BaseReset    = 11'd1792;
  localparam logic [15:0] TimeoutReset = 16'd3000;
  localparam logic [15:0] WaitReset    = 16'd3000;

  typedef enum logic [1:0] {
    ACT_HEARTBEAT = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_ARM       = 2'd2,
    ACT_NOTIFY    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_STATE   = 3'd0,
    KIND_LOST    = 3'd1,
    KIND_MET     = 3'd2,
    KIND_EXPIRED = 3'd3,
    KIND_NOTIFY  = 3'd4,
    KIND_FULL    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_BASE    = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_WAIT    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_WAIT
  } back_state_t;

  // classified command word
  typedef struct packed {
    action_t     action;
    logic        drop;
    logic [6:0]  node;
    logic [7:0]  state;
    logic [15:0] deadline;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] node;
    logic [7:0] state;
    logic       last;
  } result_t;

endpackage

// ===== design/hnm_front.sv =====
// ----------------------------------------------------------------------------
// hnm_front: input classifier
// Accepts words, decodes the frame id and state byte, picks wait deadline.
// ----------------------------------------------------------------------------
module hnm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action,
  input  logic [10:0]         can_id,
  input  logic [3:0]          data_len,
  input  logic [7:0]          first_byte,
  input  logic [6:0]          node_id,
  input  logic [7:0]          expected_state,
  input  logic [15:0]         wait_ms,
  input  logic [10:0]         heartbeat_base,
  input  logic [15:0]         default_wait_ms,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output hnm_pkg::cmd_t       cmd
);
  import hnm_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  cmd_t         queue [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  cmd_t         enc;
  logic [11:0]  diff;
  logic         do_push, do_pop;

  always_comb begin
    diff         = {1'b0, can_id} - {1'b0, heartbeat_base};
    enc.action   = action_t'(action);
    enc.drop     = (data_len == 4'd0) || diff[11] || (diff[10:7] != 4'd0);
    enc.node     = (action_t'(action) == ACT_HEARTBEAT) ? diff[6:0] : node_id;
    enc.state    = (action_t'(action) == ACT_HEARTBEAT) ?
                   (first_byte[7] ? 8'd0 : first_byte) : expected_state;
    enc.deadline = (wait_ms == 16'd0) ? default_wait_ms : wait_ms;
  end

  assign full      = (fill == (AW+1)'(QueueDepth));
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= enc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== design/hnm_back.sv =====
// ----------------------------------------------------------------------------
// hnm_back: node table and wait engine
// Executes commands against the table; a tick walks one entry per cycle while the output has room.
// ----------------------------------------------------------------------------
module hnm_back #(
  parameter int MAX_NODES = hnm_pkg::MaxNodesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  hnm_pkg::cmd_t   cmd,
  input  logic [15:0]     node_timeout_ms,
  output logic            res_valid,
  input  logic            res_ready,
  output hnm_pkg::result_t res
);
  import hnm_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [6:0]  entry_node   [MAX_NODES];
  logic [7:0]  entry_state  [MAX_NODES];
  logic [15:0] entry_age    [MAX_NODES];
  logic [MAX_NODES-1:0] entry_live, entry_notify;
  logic [CW-1:0] entry_count;

  logic        wait_armed;
  logic [6:0]  wait_node;
  logic [7:0]  wait_target;
  logic [15:0] wait_elapsed, wait_deadline;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [CW-1:0] scan;
  logic [IW-1:0] sidx;

  // pending results: up to two per command step
  result_t     r0, r1;
  logic        r0_v, r1_v;

  logic [MAX_NODES-1:0] hit;
  logic        found;
  logic [IW-1:0] slot;
  logic        full_tab;

  always_comb begin
    hit   = '0;
    found = 1'b0;
    slot  = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      hit[i] = (CW'(i) < entry_count) && (entry_node[i] == cur.node);
    end
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        slot  = IW'(i);
      end
    end
  end

  assign full_tab  = (entry_count == CW'(MAX_NODES));
  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = r0_v;
  assign res       = r0;
  assign sidx      = scan[IW-1:0];

  logic [15:0] age_inc;
  logic [15:0] el_inc;
  logic        scan_end;
  assign age_inc  = (entry_age[sidx] == 16'hFFFF) ? 16'hFFFF : entry_age[sidx] + 16'd1;
  assign el_inc   = (wait_elapsed == 16'hFFFF) ? 16'hFFFF : wait_elapsed + 16'd1;
  assign scan_end = (scan >= entry_count);

  // output slot room: room for two new results
  logic room;
  assign room = !r1_v && (!r0_v || res_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = (cmd.action == ACT_TICK) ? ST_SCAN : ST_EXEC;
      ST_EXEC: if (room) state_next = ST_IDLE;
      ST_SCAN: if (room && scan_end) state_next = ST_WAIT;
      ST_WAIT: if (room) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // results produced this cycle
  result_t n0, n1;
  logic    n0_v, n1_v;
  logic    met;
  logic    lost;
  logic    exp_now;

  always_comb begin
    n0 = '0; n1 = '0; n0_v = 1'b0; n1_v = 1'b0;
    met = 1'b0; lost = 1'b0; exp_now = 1'b0;
    unique case (state)
      ST_EXEC: begin
        unique case (cur.action)
          ACT_HEARTBEAT: begin
            if (!cur.drop && (found || !full_tab)) begin
              met  = wait_armed && wait_node == cur.node && wait_target == cur.state;
              n0_v = found && entry_notify[slot];
              n0   = '{KIND_STATE, cur.node, cur.state, !met};
              if (met) begin
                if (n0_v) begin
                  n1_v = 1'b1;
                  n1   = '{KIND_MET, cur.node, cur.state, 1'b1};
                end else begin
                  n0_v = 1'b1;
                  n0   = '{KIND_MET, cur.node, cur.state, 1'b1};
                end
              end
            end
          end
          ACT_ARM: begin
            met  = found && entry_live[slot] && entry_state[slot] == cur.state;
            n0_v = met;
            n0   = '{KIND_MET, cur.node, cur.state, 1'b1};
          end
          ACT_NOTIFY: begin
            n0_v = 1'b1;
            if (found) n0 = '{KIND_NOTIFY, cur.node, entry_state[slot], 1'b1};
            else if (full_tab) n0 = '{KIND_FULL, cur.node, 8'd0, 1'b1};
            else n0 = '{KIND_NOTIFY, cur.node, 8'd0, 1'b1};
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        lost = !scan_end && entry_live[sidx] && (age_inc > node_timeout_ms);
        n0_v = lost;
        n0   = '{KIND_LOST, entry_node[sidx], 8'hFF, 1'b0};
      end
      ST_WAIT: begin
        exp_now = wait_armed && (el_inc >= wait_deadline);
        n0_v    = exp_now;
        n0      = '{KIND_EXPIRED, wait_node, wait_target, 1'b1};
      end
      default: ;
    endcase
  end

  // last on a lost result needs lookahead; mark last by a trailer rewrite
  // held back in a hold register: the final lost is patched in the wait step after the scan ends.
  logic step;
  assign step = room && (state == ST_EXEC || state == ST_SCAN || state == ST_WAIT);

  // pending lost result held back until the next one or scan end decides last
  result_t hold;
  logic    hold_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_v <= 1'b0;
      r1_v <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      logic [2:0] k;
      result_t q [3];
      logic [1:0] cnt;
      cnt = 2'd0;
      q[0] = r0; q[1] = r1; q[2] = '0;
      // shift out popped word
      if (r0_v && res_ready) begin
        q[0] = r1;
        cnt  = {1'b0, r1_v};
      end else begin
        cnt = {1'b0, r0_v} + {1'b0, r1_v};
      end
      k = {1'b0, cnt};
      if (step) begin
        if (state == ST_SCAN) begin
          if (n0_v) begin
            if (hold_v) begin q[k[1:0]] = hold; k = k + 3'd1; end
            hold   <= n0;
            hold_v <= 1'b1;
          end
        end else if (state == ST_WAIT) begin
          if (hold_v) begin
            q[k[1:0]] = '{hold.kind, hold.node, hold.state, !n0_v};
            k = k + 3'd1;
          end
          hold_v <= 1'b0;
          if (n0_v) begin q[k[1:0]] = n0; k = k + 3'd1; end
        end else begin
          if (n0_v) begin q[k[1:0]] = n0; k = k + 3'd1; end
          if (n1_v) begin q[k[1:0]] = n1; k = k + 3'd1; end
        end
      end
      r0 <= q[0];
      r1 <= q[1];
      r0_v <= (k != 3'd0);
      r1_v <= (k >= 3'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= '0;
      entry_live   <= '0;
      entry_notify <= '0;
      wait_armed   <= 1'b0;
      wait_node    <= '0;
      wait_target  <= '0;
      wait_elapsed <= '0;
      wait_deadline <= '0;
      scan         <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        entry_state[i] <= '0;
        entry_age[i]   <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_valid) begin
        cur  <= cmd;
        scan <= '0;
      end
      if (step) begin
        unique case (state)
          ST_EXEC: begin
            unique case (cur.action)
              ACT_HEARTBEAT: begin
                if (!cur.drop && (found || !full_tab)) begin
                  if (found) begin
                    entry_state[slot] <= cur.state;
                    entry_live[slot]  <= 1'b1;
                    entry_age[slot]   <= '0;
                  end else begin
                    entry_node[entry_count[IW-1:0]]  <= cur.node;
                    entry_state[entry_count[IW-1:0]] <= cur.state;
                    entry_live[entry_count[IW-1:0]]  <= 1'b1;
                    entry_age[entry_count[IW-1:0]]   <= '0;
                    entry_count <= entry_count + 1'b1;
                  end
                  if (met) wait_armed <= 1'b0;
                end
              end
              ACT_ARM: begin
                wait_node     <= cur.node;
                wait_target   <= cur.state;
                wait_elapsed  <= '0;
                wait_deadline <= cur.deadline;
                wait_armed    <= !met;
              end
              ACT_NOTIFY: begin
                if (found) entry_notify[slot] <= 1'b1;
                else if (!full_tab) begin
                  entry_node[entry_count[IW-1:0]]   <= cur.node;
                  entry_notify[entry_count[IW-1:0]] <= 1'b1;
                  entry_count <= entry_count + 1'b1;
                end
              end
              default: ;
            endcase
          end
          ST_SCAN: begin
            if (!scan_end) begin
              entry_age[sidx] <= age_inc;
              if (lost) begin
                entry_live[sidx]  <= 1'b0;
                entry_state[sidx] <= 8'hFF;
              end
              scan <= scan + 1'b1;
            end
          end
          ST_WAIT: begin
            if (wait_armed) begin
              wait_elapsed <= el_inc;
              if (exp_now) wait_armed <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/heartbeat_node_monitor_top.sv =====
// A frame, wait or notify word is queued, latched by the back end while idle, executed
// and registered into the output slots; a tick walks the table entries, then the wait.
// The back end takes no new word until it is through with the last; a tick holds it
// for its whole table walk. A 4-word queue decouples input; output stalls stall the back.
// Reset: synchronous, clears the table count, live/notify bits, wait and queues.
// ----------------------------------------------------------------------------
// heartbeat_node_monitor_top: heartbeat consumer for remote bus nodes
// Classifier front end, command queue, table back end with two-word output.
// ----------------------------------------------------------------------------
module heartbeat_node_monitor_top #(
  parameter int MAX_NODES = hnm_pkg::MaxNodesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [10:0] can_id,
  input  logic [3:0]  data_len,
  input  logic [7:0]  first_byte,
  input  logic [6:0]  node_id,
  input  logic [7:0]  expected_state,
  input  logic [15:0] wait_ms,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [6:0]  report_node,
  output logic [7:0]  report_state,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hnm_pkg::*;

  logic [10:0] heartbeat_base;
  logic [15:0] node_timeout_ms, default_wait_ms;
  logic        cmd_valid, cmd_ready, res_valid;
  cmd_t        cmd;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_base  <= BaseReset;
      node_timeout_ms <= TimeoutReset;
      default_wait_ms <= WaitReset;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE:    heartbeat_base  <= cfg_data[10:0];
        REG_TIMEOUT: node_timeout_ms <= cfg_data;
        REG_WAIT:    default_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  hnm_front u_front (
    .clk, .rst, .push, .full, .action, .can_id, .data_len, .first_byte,
    .node_id, .expected_state, .wait_ms, .heartbeat_base, .default_wait_ms,
    .cmd_valid, .cmd_ready, .cmd
  );

  hnm_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .node_timeout_ms,
    .res_valid, .res_ready(pop), .res
  );

  assign empty        = !res_valid;
  assign kind         = res.kind;
  assign report_node  = res.node;
  assign report_state = res.state;
  assign last         = res.last;

`ifndef SYNTHESIS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind <= KIND_FULL)) else $error("bad kind");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(report_node)))
    else $error("result changed while stalled");
  a_lost_state: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_LOST) |-> report_state == 8'hFF)
    else $error("lost without disconnected state");
`endif

endmodule

// ===== bench/heartbeat_node_monitor_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_node_monitor_top_test: self-checking bench for the heartbeat monitor
// A queue-fed driver pushes frames, ticks, wait and notify words; a behavioural
// table model predicts every report word, which the monitor checks in order.
// ----------------------------------------------------------------------------
module heartbeat_node_monitor_top_test;
  import hnm_pkg::*;

  localparam int Nodes = 16;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    action_t     act;
    logic [10:0] id;
    logic [3:0]  dlen;
    logic [7:0]  byte0;
    logic [6:0]  node;
    logic [7:0]  want;
    logic [15:0] wms;
  } hb_word_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [1:0] action = 0;
  logic [10:0] can_id = 0;
  logic [3:0] data_len = 0;
  logic [7:0] first_byte = 0;
  logic [6:0] node_id = 0;
  logic [7:0] expected_state = 0;
  logic [15:0] wait_ms = 0;
  logic empty;
  logic pop = 0;
  logic [2:0] kind;
  logic [6:0] report_node;
  logic [7:0] report_state;
  logic last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  heartbeat_node_monitor_top uut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [10:0] base_r;
  logic [15:0] timeout_r, defwait_r;
  logic [6:0]  tbl_node [Nodes];
  logic        tbl_live [Nodes];
  logic [7:0]  tbl_state [Nodes];
  logic [15:0] tbl_age [Nodes];
  logic        tbl_notify [Nodes];
  int          tbl_count;
  logic        w_armed;
  logic [6:0]  w_node;
  logic [7:0]  w_target;
  logic [15:0] w_elapsed, w_deadline;

  hb_word_t pending_words [$];
  result_t  expected_reports [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 24, recv_idle = 57;
  int hold_off = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int find_slot(input logic [6:0] n);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_node[i] == n) return i;
    return -1;
  endfunction

  function automatic int claim_slot(input logic [6:0] n);
    int s;
    s = find_slot(n);
    if (s >= 0) return s;
    if (tbl_count >= Nodes) return -1;
    tbl_node[tbl_count] = n;
    tbl_live[tbl_count] = 0;
    tbl_state[tbl_count] = 0;
    tbl_age[tbl_count] = 0;
    tbl_notify[tbl_count] = 0;
    tbl_count++;
    return tbl_count - 1;
  endfunction

  task automatic add_report(input kind_t k, input logic [6:0] n, input logic [7:0] st,
                            inout int cnt);
    result_t r;
    r.kind = k;
    r.node = n;
    r.state = st;
    r.last = 0;
    expected_reports.push_back(r);
    cnt++;
  endtask

  task automatic predict_reports(input hb_word_t w);
    int cnt, s, idv;
    logic [7:0] st;
    cnt = 0;
    case (w.act)
      ACT_HEARTBEAT: begin
        idv = int'(w.id) - int'(base_r);
        if (w.dlen != 0 && idv >= 0 && idv <= 127) begin
          s = claim_slot(idv[6:0]);
          if (s >= 0) begin
            st = w.byte0[7] ? 8'd0 : w.byte0;
            tbl_state[s] = st;
            tbl_live[s] = 1;
            tbl_age[s] = 0;
            if (tbl_notify[s]) add_report(KIND_STATE, idv[6:0], st, cnt);
            if (w_armed && w_node == idv[6:0] && w_target == st) begin
              w_armed = 0;
              add_report(KIND_MET, idv[6:0], st, cnt);
            end
          end
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_age[i] != 16'hFFFF) tbl_age[i]++;
          if (tbl_live[i] && tbl_age[i] > timeout_r) begin
            tbl_live[i] = 0;
            tbl_state[i] = 8'd255;
            add_report(KIND_LOST, tbl_node[i], 8'd255, cnt);
          end
        end
        if (w_armed) begin
          if (w_elapsed != 16'hFFFF) w_elapsed++;
          if (w_elapsed >= w_deadline) begin
            w_armed = 0;
            add_report(KIND_EXPIRED, w_node, w_target, cnt);
          end
        end
      end
      ACT_ARM: begin
        w_node = w.node;
        w_target = w.want;
        w_elapsed = 0;
        w_deadline = (w.wms != 0) ? w.wms : defwait_r;
        w_armed = 1;
        s = find_slot(w.node);
        if (s >= 0 && tbl_live[s] && tbl_state[s] == w.want) begin
          w_armed = 0;
          add_report(KIND_MET, w.node, w.want, cnt);
        end
      end
      default: begin
        s = claim_slot(w.node);
        if (s < 0) add_report(KIND_FULL, w.node, 8'd0, cnt);
        else begin
          tbl_notify[s] = 1;
          add_report(KIND_NOTIFY, w.node, tbl_state[s], cnt);
        end
      end
    endcase
    if (cnt > 0) expected_reports[$].last = 1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 0;
    end else begin
      if (push && !full) begin
        predict_reports(pending_words.pop_front());
      end
      if ((!push || !full) ) begin
        if (pending_words.size() > 0 && !($urandom_range(99) < send_idle)) begin
          push <= 1;
          action <= pending_words[0].act;
          can_id <= pending_words[0].id;
          data_len <= pending_words[0].dlen;
          first_byte <= pending_words[0].byte0;
          node_id <= pending_words[0].node;
          expected_state <= pending_words[0].want;
          wait_ms <= pending_words[0].wms;
        end else begin
          push <= 0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (!rst && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected word kind %0d node %0d", kind, report_node));
      end else begin
        e = expected_reports.pop_front();
        if (kind != e.kind)
          report($sformatf("kind %0d, want %0d", kind, e.kind));
        if (report_node != e.node)
          report($sformatf("node %0d, want %0d", report_node, e.node));
        if (report_state != e.state)
          report($sformatf("state %0d, want %0d", report_state, e.state));
        if (last != e.last)
          report($sformatf("last %0d, want %0d", last, e.last));
      end
    end
    if (rst) pop <= 0;
    else pop <= (hold_off == 0) && !($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("heartbeat_node_monitor_top_test: done, errors");
      $finish;
    end
  end

  function automatic hb_word_t mk(input action_t a, input logic [10:0] id,
                                  input logic [3:0] dl, input logic [7:0] b,
                                  input logic [6:0] n, input logic [7:0] ws,
                                  input logic [15:0] ms);
    hb_word_t w;
    w.act = a; w.id = id; w.dlen = dl; w.byte0 = b;
    w.node = n; w.want = ws; w.wms = ms;
    return w;
  endfunction

  function automatic hb_word_t rand_word(input int pool);
    int r;
    logic [6:0] n;
    hb_word_t w;
    r = $urandom_range(99);
    n = 7'($urandom_range(pool - 1));
    w = mk(action_t'($urandom_range(3)), 11'($urandom), 4'($urandom_range(8)),
           8'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
    if (r < 40) begin
      w.act = ACT_HEARTBEAT;
      w.id = base_r + n;
      w.dlen = 4'($urandom_range(1, 8));
      w.byte0 = ($urandom_range(3) == 0) ? 8'd5 : 8'($urandom);
    end else if (r < 70) begin
      w.act = ACT_TICK;
    end else if (r < 82) begin
      w.act = ACT_ARM;
      w.node = n;
      w.want = ($urandom_range(1) != 0) ? 8'd5 : 8'($urandom);
      w.wms = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    end else if (r < 92) begin
      w.act = ACT_NOTIFY;
      w.node = n;
    end
    return w;
  endfunction

  task automatic drain;
    while (pending_words.size() > 0 || push || expected_reports.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
    case (idx)
      REG_BASE:    base_r = v[10:0];
      REG_TIMEOUT: timeout_r = v;
      default:     defwait_r = v;
    endcase
  endtask

  task automatic reset_model;
    base_r = BaseReset;
    timeout_r = TimeoutReset;
    defwait_r = WaitReset;
    tbl_count = 0;
    w_armed = 0; w_node = 0; w_target = 0; w_elapsed = 0; w_deadline = 0;
  endtask

  task automatic random_phase(input int cnt, input int pool);
    for (int i = 0; i < cnt; i++) pending_words.push_back(rand_word(pool));
    drain();
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset settings, drops, both state paths, waits, table full
    write_reg(REG_TIMEOUT, 16'd2);
    write_reg(REG_WAIT, 16'd0);
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1792, 4'd0, 8'd3, '0, '0, '0));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1791, 4'd8, 8'd3, '0, '0, '0));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1920, 4'd8, 8'd3, '0, '0, '0));
    pending_words.push_back(mk(ACT_NOTIFY, '0, '0, '0, 7'd127, '0, '0));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1919, 4'd1, 8'hFF, '0, '0, '0));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1919, 4'd15, 8'h7F, '0, '0, '0));
    pending_words.push_back(mk(ACT_ARM, '0, '0, '0, 7'd127, 8'h7F, 16'hFFFF));
    pending_words.push_back(mk(ACT_ARM, '0, '0, '0, 7'd0, 8'd9, 16'd0));
    pending_words.push_back(mk(ACT_TICK, '0, '0, '0, '0, '0, '0));
    pending_words.push_back(mk(ACT_ARM, '0, '0, '0, 7'd127, 8'd0, 16'd2));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1919, 4'd2, 8'h80, '0, '0, '0));
    for (int i = 0; i < 3; i++)
      pending_words.push_back(mk(ACT_TICK, '0, '0, '0, '0, '0, '0));
    for (int i = 0; i < 16; i++)
      pending_words.push_back(mk(ACT_NOTIFY, '0, '0, '0, 7'(i), '0, '0));
    pending_words.push_back(mk(ACT_HEARTBEAT, 11'd1792 + 11'd40, 4'd1, 8'd1, '0, '0, '0));
    drain();

    // long receiver stall while the sender keeps pushing
    write_reg(REG_BASE, 16'd0);
    hold_off = 400;
    random_phase(60, 16);

    write_reg(REG_BASE, 16'd2047);
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_WAIT, 16'd1);
    random_phase(20, 16);

    send_idle = 57; recv_idle = 24;
    write_reg(REG_BASE, 16'd300);
    write_reg(REG_TIMEOUT, 16'd4);
    write_reg(REG_WAIT, 16'd65535);
    random_phase(100, 20);

    send_idle = 0; recv_idle = 0;
    write_reg(REG_TIMEOUT, 16'd65535);
    write_reg(REG_WAIT, 16'd3);
    random_phase(110, 20);

    if (errors == 0) begin
      $display("heartbeat_node_monitor_top_test: done, clean");
    end else begin
      $display("heartbeat_node_monitor_top_test: done, errors");
    end
    $finish;
  end
endmodule
